// ===== hdl/rthc_pkg.sv =====
package rthc_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 15;
    localparam int SAT_W      = 17;
    localparam int LIGHT_W    = 9;

    // hue in 1/64 degree
    localparam int HUE_SIXTH      = 3840;
    localparam int HUE_FULL       = 23040;
    localparam int HUE_BASE_GREEN = 7680;
    localparam int HUE_BASE_BLUE  = 15360;
    localparam int SAT_ONE        = 65536;
    localparam int SAT_FRAC       = 16;

    // hue numerator 3840 * |diff| + d - 1 fits 20 bits; saturation numerator d << 16
    localparam int HUE_NUM_W  = 20;
    localparam int SAT_NUM_W  = CH_W + SAT_FRAC;
    localparam int HUE_Q_W    = 13;

    // divider: two quotient bits per stage
    localparam int DIV_STAGES = 9;
    localparam int QUO_W      = 2 * DIV_STAGES;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

// ===== hdl/rthc_pix_if.sv =====
interface rthc_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rthc_pkg::CH_W-1:0] red;
    logic [rthc_pkg::CH_W-1:0] green;
    logic [rthc_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/rthc_hsl_if.sv =====
interface rthc_hsl_if;
    logic                         valid;
    logic                         ready;
    logic [rthc_pkg::HUE_W-1:0]   hue;
    logic [rthc_pkg::SAT_W-1:0]   saturation;
    logic [rthc_pkg::LIGHT_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

// ===== hdl/rthc_div.sv =====
module rthc_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 8,
    parameter int STAGES = 9
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic [2*STAGES-1:0]   quo
);

    // restoring division, two quotient bits per stage;
    // requires num < den * 2**(2*STAGES)
    localparam int QW    = 2 * STAGES;
    localparam int EXT_W = DEN_W + QW;

    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [QW-1:0]    w_reg   [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];

    logic [EXT_W-1:0] num_ext;

    assign num_ext = EXT_W'(num);

    function automatic logic [EXT_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [QW-1:0]    w,
        input logic [DEN_W-1:0] dv
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] t_sub;
        t     = {rem, w[QW-1]};
        t_sub = t - {1'b0, dv};
        if (t >= {1'b0, dv})
        begin
            return {t_sub[DEN_W-1:0], w[QW-2:0], 1'b1};
        end
        return {t[DEN_W-1:0], w[QW-2:0], 1'b0};
    endfunction

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QW-1:0]    w_in;
        logic [DEN_W-1:0] den_in;
        logic [EXT_W-1:0] step_a;
        logic [EXT_W-1:0] step_b;

        if (s == 0)
        begin : g_first
            assign rem_in = num_ext[EXT_W-1:QW];
            assign w_in   = num_ext[QW-1:0];
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign w_in   = w_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            step_a = div_step(rem_in, w_in, den_in);
            step_b = div_step(step_a[EXT_W-1:QW], step_a[QW-1:0], den_in);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= step_b[EXT_W-1:QW];
                w_reg[s]   <= step_b[QW-1:0];
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = w_reg[STAGES-1];

endmodule

// ===== hdl/rgb_to_hsl_convert_top.sv =====
// Each pixel word passes the stage 1 and stage 2 registers, the nine divider stages and
// the output register before its result word is valid at the output.
// Throughput: one word per cycle when not stalled; the nine-stage dividers take a new
// word every cycle. A stall at the output holds every stage in place.
// Reset clears all valid bits; data registers are not reset.
module rgb_to_hsl_convert_top (
    input  logic       clk,
    input  logic       rst_n,
    rthc_pix_if.sink   pixel,
    rthc_hsl_if.source color
);

    localparam int NS = rthc_pkg::DIV_STAGES;

    logic en;

    // stage 1: max, min, sector, sign and magnitude of the hue difference
    logic [rthc_pkg::CH_W-1:0] mx;
    logic [rthc_pkg::CH_W-1:0] mn;
    rthc_pkg::sector_t         sec;
    logic [rthc_pkg::CH_W:0]   diff;
    logic [rthc_pkg::CH_W:0]   diff_neg;

    logic                      s1_valid_reg;
    logic [rthc_pkg::CH_W-1:0] s1_mx_reg;
    logic [rthc_pkg::CH_W-1:0] s1_mn_reg;
    rthc_pkg::sector_t         s1_sec_reg;
    logic                      s1_neg_reg;
    logic [rthc_pkg::CH_W-1:0] s1_mag_reg;

    // stage 2: numerators, divisors, lightness and grey flag
    logic [rthc_pkg::CH_W-1:0]      d;
    logic [rthc_pkg::LIGHT_W-1:0]   light;
    logic [rthc_pkg::CH_W-1:0]      denom;
    logic [rthc_pkg::HUE_NUM_W-1:0] hue_num;

    logic                           s2_valid_reg;
    logic [rthc_pkg::HUE_NUM_W-1:0] s2_hue_num_reg;
    logic [rthc_pkg::CH_W-1:0]      s2_d_reg;
    logic [rthc_pkg::SAT_NUM_W-1:0] s2_sat_num_reg;
    logic [rthc_pkg::CH_W-1:0]      s2_denom_reg;
    rthc_pkg::sector_t              s2_sec_reg;
    logic                           s2_neg_reg;
    logic                           s2_grey_reg;
    logic [rthc_pkg::LIGHT_W-1:0]   s2_light_reg;

    // divider stages
    logic [NS-1:0]                dv_valid_reg;
    rthc_pkg::sector_t            sb_sec_reg   [NS];
    logic                         sb_neg_reg   [NS];
    logic                         sb_grey_reg  [NS];
    logic [rthc_pkg::LIGHT_W-1:0] sb_light_reg [NS];
    logic [rthc_pkg::QUO_W-1:0]   hue_quo;
    logic [rthc_pkg::QUO_W-1:0]   sat_quo;

    // final
    logic [rthc_pkg::HUE_Q_W-1:0] hq;
    logic [rthc_pkg::HUE_W-1:0]   hue_next;
    logic [rthc_pkg::SAT_W-1:0]   sat_next;

    logic                         out_valid_reg;
    logic [rthc_pkg::HUE_W-1:0]   hue_reg;
    logic [rthc_pkg::SAT_W-1:0]   sat_reg;
    logic [rthc_pkg::LIGHT_W-1:0] light_reg;

    assign en          = !out_valid_reg || color.ready;
    assign pixel.ready = en;

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx)
        begin
            mx = pixel.green;
        end
        if (pixel.blue > mx)
        begin
            mx = pixel.blue;
        end
        if (pixel.green < mn)
        begin
            mn = pixel.green;
        end
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end

        if (pixel.blue == mx)
        begin
            sec  = rthc_pkg::SEC_BLUE;
            diff = {1'b0, pixel.red} - {1'b0, pixel.green};
        end
        else if (pixel.green == mx)
        begin
            sec  = rthc_pkg::SEC_GREEN;
            diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
        end
        else
        begin
            sec  = rthc_pkg::SEC_RED;
            diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
        end
        diff_neg = '0 - diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mx_reg  <= mx;
            s1_mn_reg  <= mn;
            s1_sec_reg <= sec;
            s1_neg_reg <= diff[rthc_pkg::CH_W];
            s1_mag_reg <= diff[rthc_pkg::CH_W] ? diff_neg[rthc_pkg::CH_W-1:0]
                                               : diff[rthc_pkg::CH_W-1:0];
        end
    end

    // 3840 * mag = mag * 4096 - mag * 256; a negative part rounds up by adding d - 1
    always_comb
    begin
        d       = s1_mx_reg - s1_mn_reg;
        light   = rthc_pkg::LIGHT_W'(s1_mx_reg) + rthc_pkg::LIGHT_W'(s1_mn_reg);
        denom   = (light > rthc_pkg::LIGHT_W'(255))
                ? rthc_pkg::CH_W'(rthc_pkg::LIGHT_W'(510) - light)
                : light[rthc_pkg::CH_W-1:0];
        hue_num = (rthc_pkg::HUE_NUM_W'(s1_mag_reg) << 12)
                - (rthc_pkg::HUE_NUM_W'(s1_mag_reg) << 8);
        if (s1_neg_reg)
        begin
            hue_num = hue_num + rthc_pkg::HUE_NUM_W'(d) - rthc_pkg::HUE_NUM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hue_num_reg <= hue_num;
            s2_d_reg       <= d;
            s2_sat_num_reg <= {d, {rthc_pkg::SAT_FRAC{1'b0}}};
            s2_denom_reg   <= denom;
            s2_sec_reg     <= s1_sec_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_grey_reg    <= (d == '0);
            s2_light_reg   <= light;
        end
    end

    rthc_div #(
        .NUM_W  (rthc_pkg::HUE_NUM_W),
        .DEN_W  (rthc_pkg::CH_W),
        .STAGES (rthc_pkg::DIV_STAGES)
    ) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (s2_hue_num_reg),
        .den (s2_d_reg),
        .quo (hue_quo)
    );

    rthc_div #(
        .NUM_W  (rthc_pkg::SAT_NUM_W),
        .DEN_W  (rthc_pkg::CH_W),
        .STAGES (rthc_pkg::DIV_STAGES)
    ) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (s2_sat_num_reg),
        .den (s2_denom_reg),
        .quo (sat_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (en)
        begin
            dv_valid_reg <= {dv_valid_reg[NS-2:0], s2_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_sec_reg[0]   <= s2_sec_reg;
            sb_neg_reg[0]   <= s2_neg_reg;
            sb_grey_reg[0]  <= s2_grey_reg;
            sb_light_reg[0] <= s2_light_reg;
            for (int i = 1; i < NS; i++)
            begin
                sb_sec_reg[i]   <= sb_sec_reg[i-1];
                sb_neg_reg[i]   <= sb_neg_reg[i-1];
                sb_grey_reg[i]  <= sb_grey_reg[i-1];
                sb_light_reg[i] <= sb_light_reg[i-1];
            end
        end
    end

    always_comb
    begin
        hq = hue_quo[rthc_pkg::HUE_Q_W-1:0];
        case (sb_sec_reg[NS-1])
            rthc_pkg::SEC_BLUE:
            begin
                hue_next = sb_neg_reg[NS-1]
                         ? rthc_pkg::HUE_W'(rthc_pkg::HUE_BASE_BLUE) - rthc_pkg::HUE_W'(hq)
                         : rthc_pkg::HUE_W'(rthc_pkg::HUE_BASE_BLUE) + rthc_pkg::HUE_W'(hq);
            end
            rthc_pkg::SEC_GREEN:
            begin
                hue_next = sb_neg_reg[NS-1]
                         ? rthc_pkg::HUE_W'(rthc_pkg::HUE_BASE_GREEN) - rthc_pkg::HUE_W'(hq)
                         : rthc_pkg::HUE_W'(rthc_pkg::HUE_BASE_GREEN) + rthc_pkg::HUE_W'(hq);
            end
            rthc_pkg::SEC_RED:
            begin
                if (sb_neg_reg[NS-1] && (hq != '0))
                begin
                    hue_next = rthc_pkg::HUE_W'(rthc_pkg::HUE_FULL) - rthc_pkg::HUE_W'(hq);
                end
                else
                begin
                    hue_next = rthc_pkg::HUE_W'(hq);
                end
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        sat_next = sat_quo[rthc_pkg::SAT_W-1:0];
        if (sb_grey_reg[NS-1])
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= sb_light_reg[NS-1];
        end
    end

    assign color.valid      = out_valid_reg;
    assign color.hue        = hue_reg;
    assign color.saturation = sat_reg;
    assign color.lightness  = light_reg;

    // zero saturation only for grey pixels, which carry zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && (color.saturation == '0) |-> (color.hue == '0))
        else $error("nonzero hue on grey pixel");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid |-> (color.hue < rthc_pkg::HUE_W'(rthc_pkg::HUE_FULL)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid |-> (color.saturation <= rthc_pkg::SAT_W'(rthc_pkg::SAT_ONE)))
        else $error("saturation above one");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({s1_valid_reg, s2_valid_reg, dv_valid_reg}))
        else $error("pipeline moved during stall");

endmodule

// ===== test/hsl_result_checker.sv =====
`timescale 1ns / 1ps

module hsl_result_checker
    import rthc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rthc_pix_if  pixel,
    rthc_hsl_if  color,
    output int   failures,
    output int   outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   saturation;
        logic [LIGHT_W-1:0] lightness;
    } hsl_prediction_t;

    hsl_prediction_t predicted_hsl [$];
    int              mismatch_count = 0;
    int              queued_words = 0;

    assign failures    = mismatch_count;
    assign outstanding = queued_words;

    // floor(HUE_SIXTH * num / span), |num| <= span, span > 0
    function automatic int sixth_frac(input int num, input int span);
        if (num >= 0)
            return (HUE_SIXTH * num) / span;
        return -((HUE_SIXTH * (-num) + span - 1) / span);
    endfunction

    function automatic hsl_prediction_t predict_hsl(input logic [CH_W-1:0] r,
                                                    input logic [CH_W-1:0] g,
                                                    input logic [CH_W-1:0] b);
        int              hi;
        int              lo;
        int              span;
        int              light;
        int              denom;
        int              sat;
        int              hue;
        hsl_prediction_t p;
        hi = int'(r);
        lo = int'(r);
        if (int'(g) > hi) hi = int'(g);
        if (int'(b) > hi) hi = int'(b);
        if (int'(g) < lo) lo = int'(g);
        if (int'(b) < lo) lo = int'(b);
        span  = hi - lo;
        light = hi + lo;
        hue   = 0;
        sat   = 0;
        if (span != 0)
        begin
            // blue wins ties, then green, then red
            if (int'(b) == hi)
                hue = HUE_BASE_BLUE + sixth_frac(int'(r) - int'(g), span);
            else if (int'(g) == hi)
                hue = HUE_BASE_GREEN + sixth_frac(int'(b) - int'(r), span);
            else
            begin
                hue = sixth_frac(int'(g) - int'(b), span);
                if (hue < 0)
                    hue += HUE_FULL;
            end
            if (hue < 0)
                hue = 0;
            if (hue >= HUE_FULL)
                hue -= HUE_FULL;
            denom = (light > 255) ? (510 - light) : light;
            if (denom != 0)
                sat = (span << SAT_FRAC) / denom;
            if (sat > SAT_ONE)
                sat = SAT_ONE;
        end
        p.red        = r;
        p.green      = g;
        p.blue       = b;
        p.hue        = HUE_W'(hue);
        p.saturation = SAT_W'(sat);
        p.lightness  = LIGHT_W'(light);
        return p;
    endfunction

    always @(posedge clk)
    begin : compare_words
        hsl_prediction_t want;
        if (rst_n)
        begin
            if (pixel.valid && pixel.ready)
            begin
                predicted_hsl.push_back(predict_hsl(pixel.red, pixel.green, pixel.blue));
                queued_words++;
            end
            if (color.valid && color.ready)
            begin
                if (predicted_hsl.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected hsl word h=%0d s=%0d l=%0d", $realtime,
                                 color.hue, color.saturation, color.lightness);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_hsl.pop_front();
                    queued_words--;
                    if (color.hue !== want.hue || color.saturation !== want.saturation ||
                        color.lightness !== want.lightness)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $write("%0t: rgb %0d,%0d,%0d expected h=%0d s=%0d l=%0d,",
                                   $realtime, want.red, want.green, want.blue,
                                   want.hue, want.saturation, want.lightness);
                            $display(" got h=%0d s=%0d l=%0d",
                                     color.hue, color.saturation, color.lightness);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rthc_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int CORNER_COUNT    = 23;
    localparam int PIXEL_COUNT     = 950;
    localparam int MAX_GAP         = 4;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 150;
    localparam int BURST_FIRST     = 400;
    localparam int BURST_LAST      = 549;
    localparam int DRAIN_CYCLES    = 30;
    localparam int LIMIT_NS        = 3_000_000;

    logic clk;
    logic rst_n;
    int   failures;
    int   outstanding;
    bit   no_idle;

    rthc_pix_if pixel ();
    rthc_hsl_if color ();

    rgb_to_hsl_convert_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .color (color)
    );

    hsl_result_checker hsl_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .color       (color),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // enters just after an accepting edge, leaves at the edge that takes the word
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            pixel.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel.valid <= 1'b1;
        pixel.red   <= r;
        pixel.green <= g;
        pixel.blue  <= b;
        @(posedge clk);
        while (!pixel.ready) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : pixel_side
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] top;
        logic [CH_W-1:0] low;
        pixel.valid = 1'b0;
        pixel.red   = '0;
        pixel.green = '0;
        pixel.blue  = '0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        // red max with green below blue: hue wraps just under full circle
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd200, 8'd55, 8'd0);
        send_pixel(8'd201, 8'd55, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd2);
        send_pixel(8'd2, 8'd1, 8'd0);
        send_pixel(8'd17, 8'd200, 8'd90);
        send_pixel(8'd90, 8'd17, 8'd200);
        send_pixel(8'd1, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd128, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd86);

        for (int i = CORNER_COUNT; i < PIXEL_COUNT; i++)
        begin
            no_idle = (i >= BURST_FIRST && i <= BURST_LAST);
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    r = CH_W'($urandom_range(0, 255));
                    g = CH_W'($urandom_range(0, 255));
                    b = CH_W'($urandom_range(0, 255));
                end
                2:
                begin
                    // two channels tied at the maximum
                    top = CH_W'($urandom_range(1, 255));
                    low = CH_W'($urandom_range(0, top - 1));
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            r = top;
                            g = top;
                            b = low;
                        end
                        1:
                        begin
                            r = top;
                            g = low;
                            b = top;
                        end
                        default:
                        begin
                            r = low;
                            g = top;
                            b = top;
                        end
                    endcase
                end
                3:
                begin
                    // near grey
                    r = CH_W'($urandom_range(0, 255));
                    g = r ^ CH_W'($urandom_range(0, 3));
                    b = r ^ CH_W'($urandom_range(0, 3));
                end
                default:
                begin
                    r = pick_extreme();
                    g = pick_extreme();
                    b = pick_extreme();
                end
            endcase
            send_pixel(r, g, b);
        end

        @(negedge clk);
        pixel.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : color_side
        int stall;
        int words_taken;
        bit pressure_done;
        color.ready   = 1'b0;
        words_taken   = 0;
        pressure_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            // long hold-off so the pipeline fills and backs up the input
            if (!pressure_done && words_taken >= PRESSURE_AT)
            begin
                stall         = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                color.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            color.ready <= 1'b1;
            @(posedge clk);
            while (!color.valid) @(posedge clk);
            words_taken++;
        end
    end

endmodule

// ===== rgb_to_hsl_convert_top.f =====
hdl/rthc_pkg.sv
hdl/rthc_pix_if.sv
hdl/rthc_hsl_if.sv
hdl/rthc_div.sv
hdl/rgb_to_hsl_convert_top.sv
test/hsl_result_checker.sv
test/testbench.sv
